// ----- rtl/core/kdlp_pkg.sv -----
package kdlp_pkg;

  // Key count and register geometry
  localparam int NumKeys  = 2;
  localparam int CountW   = 16;
  localparam int CfgIdxW  = 2;

  localparam logic [CountW-1:0] CountMax        = {CountW{1'b1}};
  localparam logic [CountW-1:0] DebounceReset   = 16'd20;
  localparam logic [CountW-1:0] LongPressReset  = 16'd1000;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_LONG_PRESS = 2'd1;

  // Per-key phase, one-hot
  typedef enum logic [3:0] {
    PH_IDLE     = 4'b0001,
    PH_DEBOUNCE = 4'b0010,
    PH_PRESSED  = 4'b0100,
    PH_LONG     = 4'b1000
  } phase_t;

  // Tick control shared by every lane
  typedef struct packed {
    logic              step;
    logic [CountW-1:0] debounce_ticks;
    logic [CountW-1:0] long_press_ticks;
  } lane_ctrl_t;

  // What one lane finds on a tick
  typedef struct packed {
    logic short_p;
    logic long_p;
    logic held;
  } lane_res_t;

  // One result word
  typedef struct packed {
    logic [NumKeys-1:0] short_press_pulses;
    logic [NumKeys-1:0] long_press_pulses;
    logic [NumKeys-1:0] held_flags;
  } result_t;

endpackage

// ----- rtl/core/kdlp_lane.sv -----
module kdlp_lane
  import kdlp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  lane_ctrl_t ctrl_i,
  input  logic       level_i,
  output lane_res_t  res_o
);

  phase_t            phase_r, phase_nxt;
  logic [CountW-1:0] cnt_r, cnt_nxt;
  logic              held_r, held_nxt;
  logic [CountW-1:0] cnt_inc;
  logic              short_p, long_p;

  // Saturating increment of the hold count
  assign cnt_inc = (cnt_r == CountMax) ? cnt_r : cnt_r + 1'b1;

  // Advance the key machine for this tick
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    held_nxt  = held_r;
    short_p   = 1'b0;
    long_p    = 1'b0;
    unique case (phase_r)
      PH_IDLE: begin
        if (level_i) begin
          phase_nxt = PH_DEBOUNCE;
          cnt_nxt   = '0;
        end
      end
      PH_DEBOUNCE: begin
        if (level_i) begin
          cnt_nxt = cnt_inc;
          if (cnt_inc >= ctrl_i.debounce_ticks) begin
            phase_nxt = PH_PRESSED;
            held_nxt  = 1'b1;
            cnt_nxt   = '0;
          end
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_PRESSED: begin
        if (!level_i) begin
          short_p   = 1'b1;
          held_nxt  = 1'b0;
          phase_nxt = PH_IDLE;
        end else begin
          cnt_nxt = cnt_inc;
          if (cnt_inc >= ctrl_i.long_press_ticks) begin
            long_p    = 1'b1;
            phase_nxt = PH_LONG;
          end
        end
      end
      PH_LONG: begin
        if (!level_i) begin
          held_nxt  = 1'b0;
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // Hold state unless a word is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
      held_r  <= 1'b0;
    end else if (ctrl_i.step) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      held_r  <= held_nxt;
    end
  end

  assign res_o.short_p = short_p;
  assign res_o.long_p  = long_p;
  assign res_o.held    = held_nxt;

endmodule

// ----- rtl/core/kdlp_merge.sv -----
module kdlp_merge
  import kdlp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_i,
  input  lane_res_t lanes_i [NumKeys],
  output logic      space_o,
  output logic      valid_o,
  input  logic      ready_i,
  output result_t   word_o
);

  result_t     fifo_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  count_r, count_nxt;
  result_t     word_in;
  logic        pop;

  // Gather lane bits into one result word
  always_comb begin
    word_in = '0;
    for (int k = 0; k < NumKeys; k++) begin
      word_in.short_press_pulses[k] = lanes_i[k].short_p;
      word_in.long_press_pulses[k]  = lanes_i[k].long_p;
      word_in.held_flags[k]         = lanes_i[k].held;
    end
  end

  assign pop     = valid_o && ready_i;
  assign space_o = (count_r != 2'd2);
  assign valid_o = (count_r != 2'd0);
  assign word_o  = fifo_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push_i && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push_i) begin
      count_nxt = count_r - 2'd1;
    end
  end

  // Store pushed words
  always_ff @(posedge clk) begin
    if (push_i) begin
      fifo_r[wr_ptr_r] <= word_in;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

endmodule

// ----- rtl/core/key_debounce_long_press_core.sv -----
// Channel  Direction  Handshake            Payload
// in       input      in_valid/in_ready    in_key_levels
// out      output     out_valid/out_ready  out_short_press_pulses, out_long_press_pulses,
//                                          out_held_flags
// cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One tick word is taken per cycle while in_ready is high; its result is ready in the
// next cycle. Every key has its own lane updated in the tick's cycle; a two-word output
// buffer lets one more word in while a result waits, so in_ready only drops
// when two results are held. cfg_ready is always high.
// Reset (rst_n low, synchronous) returns all keys to idle and the
// thresholds to 20 and 1000 ticks.
module key_debounce_long_press_core
  import kdlp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [NumKeys-1:0] in_key_levels,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [NumKeys-1:0] out_short_press_pulses,
  output logic [NumKeys-1:0] out_long_press_pulses,
  output logic [NumKeys-1:0] out_held_flags,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CountW-1:0]  cfg_data
);

  logic [CountW-1:0] debounce_r;
  logic [CountW-1:0] long_press_r;
  lane_ctrl_t        ctrl;
  lane_res_t         lane_res [NumKeys];
  result_t           word;
  logic              space;

  assign cfg_ready = 1'b1;

  // Decode register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= DebounceReset;
      long_press_r <= LongPressReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DEBOUNCE:   debounce_r   <= cfg_data;
        REG_LONG_PRESS: long_press_r <= cfg_data;
        default:        ;
      endcase
    end
  end

  assign in_ready               = space;
  assign ctrl.step              = in_valid && in_ready;
  assign ctrl.debounce_ticks    = debounce_r;
  assign ctrl.long_press_ticks  = long_press_r;

  // One lane per key
  for (genvar k = 0; k < NumKeys; k++) begin : g_lane
    kdlp_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl_i  (ctrl),
      .level_i (in_key_levels[k]),
      .res_o   (lane_res[k])
    );
  end

  // Merge lane results and buffer the word
  kdlp_merge u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (ctrl.step),
    .lanes_i (lane_res),
    .space_o (space),
    .valid_o (out_valid),
    .ready_i (out_ready),
    .word_o  (word)
  );

  assign out_short_press_pulses = word.short_press_pulses;
  assign out_long_press_pulses  = word.long_press_pulses;
  assign out_held_flags         = word.held_flags;

  // A key never gives a short and a long press on one tick
  a_no_both: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_short_press_pulses & out_long_press_pulses) == '0))
    else $error("short and long press on one key in one word");

  // A short press releases the key
  a_short_released: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_short_press_pulses & out_held_flags) == '0))
    else $error("short press with key still held");

  // A long press happens while held
  a_long_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_long_press_pulses & ~out_held_flags) == '0))
    else $error("long press on a key not held");

  // Input stalls only when results are waiting
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

endmodule
